@@ hdl/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

    // Function codes carried on the input channel
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    localparam int CODE_MAX = 32;
    localparam int LEN_CAP  = (CODE_MAX < 32) ? CODE_MAX : 32;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int MAX_OUT = 4;
    localparam int BURST_W = MAX_OUT * BYTE_W;
    localparam int NCNT_W  = 3;   // holds 0..MAX_OUT
    localparam int PCNT_W  = 3;   // pending bit count 0..7
    localparam int PBIT_W  = 7;   // pending bits, at most seven

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
    } s_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              is_last;
    } m_item_t;

    // One table entry: capped length and raw code bits
    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } code_entry_t;

    // Item waiting in the lookup stage
    typedef struct packed {
        logic [1:0] func;
        logic       sym_ok;
    } stage_info_t;

    // Bytes produced by one item, first byte in the top bits
    typedef struct packed {
        logic [BURST_W-1:0] bytes;
        logic [NCNT_W-1:0]  count;
        logic               last;
    } burst_t;

endpackage

@@ hdl/hcbp_code_mem.sv @@
// Code table memory: one write port, one read port with registered data.
module hcbp_code_mem
    import hcbp_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  code_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output code_entry_t       rd_data
);

    code_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/hcbp_packer.sv @@
// Bit packer: merges a looked-up code with the pending partial byte.
module hcbp_packer
    import hcbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  stage_info_t info,
    input  code_entry_t entry,
    input  logic        advance,
    output burst_t      burst
);

    logic [PBIT_W-1:0] pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic [CODE_W-1:0] code_mask;
    logic [CODE_W-1:0] code_bits;
    logic [38:0]       acc;
    logic [LEN_W-1:0]  cnt;
    logic [39:0]       aligned;
    logic [PBIT_W-1:0] rem_mask;
    logic [BYTE_W-1:0] flush_byte;

    always_comb begin
        code_mask  = CODE_W'((33'd1 << entry.length) - 33'd1);
        code_bits  = entry.code & code_mask;
        acc        = (39'(pend_bits_reg) << entry.length) | 39'(code_bits);
        cnt        = LEN_W'(pend_cnt_reg) + entry.length;
        // left-align so the oldest pending bit lands in bit 39
        aligned    = {1'b0, acc} << (6'd40 - cnt);
        rem_mask   = PBIT_W'((8'd1 << cnt[2:0]) - 8'd1);
        flush_byte = {1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg});
    end

    always_comb begin
        burst          = '0;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        case (info.func)
            FUNC_ENCODE: begin
                if (info.sym_ok) begin
                    burst.bytes    = aligned[39:8];
                    burst.count    = cnt[5:3];
                    pend_bits_next = acc[PBIT_W-1:0] & rem_mask;
                    pend_cnt_next  = cnt[2:0];
                end
            end
            FUNC_FLUSH: begin
                burst.bytes    = {flush_byte, 24'd0};
                burst.count    = (pend_cnt_reg != '0) ? NCNT_W'(1) : '0;
                burst.last     = 1'b1;
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else if (advance) begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

@@ hdl/hcbp_out_queue.sv @@
// Output stage: holds up to four bytes and hands them out one per transfer.
module hcbp_out_queue
    import hcbp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  burst_t  burst,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_item
);

    logic [BURST_W-1:0] bytes_reg, bytes_next;
    logic [NCNT_W-1:0]  count_reg, count_next;
    logic               last_reg, last_next;
    logic               take;

    assign m_valid            = (count_reg != '0);
    assign take               = m_valid && m_ready;
    assign free               = (count_reg == '0) || ((count_reg == NCNT_W'(1)) && m_ready);
    assign m_item.packed_byte = bytes_reg[BURST_W-1 -: BYTE_W];
    assign m_item.is_last     = last_reg && (count_reg == NCNT_W'(1));

    always_comb begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (load) begin
            bytes_next = burst.bytes;
            count_next = burst.count;
            last_next  = burst.last;
        end else if (take) begin
            // advance to the next byte
            bytes_next = bytes_reg << BYTE_W;
            count_next = count_reg - NCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        last_reg  <= last_next;
    end

endmodule

@@ hdl/huffman_code_bit_packer_unit.sv @@
// Huffman code bit packer top level: table memory, packer and output stage.
//
// Input channel s_valid/s_ready/s_item carries load, encode and flush items.
// A load writes a symbol's code and length into the table; an encode looks
// the symbol up and appends its code, MSB first, to the pending bits; a
// flush emits the partial byte left-aligned with zero padding, tagged last.
// Result channel m_valid/m_ready/m_item carries one packed byte per transfer.
// The table read and the lookup stage register the item at its transfer;
// the packer merges the code combinationally, and the output stage
// registers the bytes once it is free and shows them on m_item.
// Throughput: one item per cycle while each item yields at most one byte
// and m_ready stays high. An encode that fills more bytes holds the output
// stage until all have moved, since the result port moves one byte per
// cycle; a 32-bit code fills up to four bytes. Loads, flushes with nothing
// pending and short codes move at one per cycle.
// Reset (aresetn low, synchronous) empties the pipeline and the pending
// bits; the code table keeps its contents and must be loaded before use.
// A stalled result holds m_item steady; the lookup stage then holds an item
// with bytes, and s_ready drops until the output stage can take them.
module huffman_code_bit_packer_unit
    import hcbp_pkg::*;
#(
    parameter int SYMBOLS = 256
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  s_item_t s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_item
);

    localparam int ADDR_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

    logic        s_xfer;
    logic        sym_ok;
    logic        s1_valid_reg, s1_valid_next;
    stage_info_t s1_info_reg, s1_info_next;
    logic        advance;
    logic        out_free;
    burst_t      burst;
    code_entry_t wr_entry;
    code_entry_t rd_entry;

    assign s_xfer = s_valid && s_ready;
    assign sym_ok = (9'(s_item.symbol) < 9'(SYMBOLS));

    always_comb begin
        wr_entry.code   = s_item.code_value;
        wr_entry.length = (s_item.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                                 : s_item.code_length;
    end

    hcbp_code_mem #(
        .DEPTH  (SYMBOLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (s_xfer && (s_item.func == FUNC_LOAD) && sym_ok),
        .wr_addr (s_item.symbol[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (s_xfer && (s_item.func == FUNC_ENCODE) && sym_ok),
        .rd_addr (s_item.symbol[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    hcbp_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .info    (s1_info_reg),
        .entry   (rd_entry),
        .advance (advance),
        .burst   (burst)
    );

    // An item with no bytes leaves without waiting for the output stage
    assign advance = s1_valid_reg && ((burst.count == '0) || out_free);
    assign s_ready = !s1_valid_reg || advance;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_info_next  = s1_info_reg;
        if (s_ready) begin
            s1_valid_next       = s_valid;
            s1_info_next.func   = s_item.func;
            s1_info_next.sym_ok = sym_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_info_reg <= s1_info_next;
    end

    hcbp_out_queue u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && (burst.count != '0)),
        .burst   (burst),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

@@ hdl/hcbp_checker.sv @@
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_checker
    import hcbp_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input m_item_t m_item
);

    logic s_xfer;
    assign s_xfer = s_valid && s_ready;

    // A stalled result byte stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // With nothing accepted and nothing shown, no byte may appear
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!m_valid) && $past(!s_xfer) |=> !m_valid)
        else $error("result byte without a source item");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

@@ bench/tb_top.sv @@
// Testbench for the Huffman code bit packer: random item driver, byte predictor and checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    s_item_t s_item;
    logic    m_valid;
    logic    m_ready;
    m_item_t m_item;

    huffman_code_bit_packer_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Stimulus and expected output bytes
    s_item_t items_to_send[$];
    m_item_t due_bytes[$];

    // Predictor copy of the code table and the partial byte
    logic [CODE_W-1:0] code_mem [256];
    logic [LEN_W-1:0]  len_mem  [256];
    logic [7:0]        pend_bits;
    int unsigned       pend_cnt;

    // Generator bookkeeping: only loaded symbols get encoded
    bit         loaded [256];
    logic [7:0] live_syms[$];

    int unsigned err_cnt;
    int unsigned n_loads, n_encodes, n_flushes, n_bytes, n_last;

    logic        s_took, m_took;
    int unsigned s_gap, m_gap;
    bit          s_quiet, m_quiet;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("** huffman_code_bit_packer_unit: FAILED **");
        $finish;
    end

    function automatic int unsigned idle_draw(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // Advance the packer state by one accepted item, queue the bytes it fills
    task automatic pack_code_bytes(input s_item_t it);
        int unsigned l;
        int unsigned cnt;
        logic [63:0] acc;
        logic [63:0] acc_sh;
        m_item_t     nb;
        case (it.func)
            FUNC_LOAD: begin
                n_loads++;
                code_mem[it.symbol] = it.code_value;
                len_mem[it.symbol]  = (it.code_length > LEN_CAP) ? LEN_W'(LEN_CAP)
                                                                 : it.code_length;
            end
            FUNC_ENCODE: begin
                n_encodes++;
                l   = len_mem[it.symbol];
                acc = ({56'd0, pend_bits} << l)
                    | ({32'd0, code_mem[it.symbol]} & ((64'd1 << l) - 64'd1));
                cnt = pend_cnt + l;
                while (cnt >= 8) begin
                    cnt            -= 8;
                    acc_sh          = acc >> cnt;
                    nb.packed_byte  = acc_sh[7:0];
                    nb.is_last      = 1'b0;
                    due_bytes.push_back(nb);
                end
                acc       = acc & ((64'd1 << cnt) - 64'd1);
                pend_bits = acc[7:0];
                pend_cnt  = cnt;
            end
            FUNC_FLUSH: begin
                n_flushes++;
                if (pend_cnt != 0) begin
                    nb.packed_byte = pend_bits << (8 - pend_cnt);
                    nb.is_last     = 1'b1;
                    due_bytes.push_back(nb);
                end
                pend_bits = '0;
                pend_cnt  = 0;
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [1:0] func, input logic [7:0] sym,
                              input logic [31:0] val, input logic [5:0] len);
        s_item_t it;
        it.func        = func;
        it.symbol      = sym;
        it.code_value  = val;
        it.code_length = len;
        items_to_send.push_back(it);
        if (func == FUNC_LOAD && !loaded[sym]) begin
            loaded[sym] = 1'b1;
            live_syms.push_back(sym);
        end
    endtask

    // Mostly short codes, some long ones, a few zero and over-cap lengths
    function automatic logic [5:0] draw_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 6'd0;
        else if (r == 1)
            return 6'($urandom_range(33, 63));
        else if (r < 5)
            return 6'($urandom_range(13, 32));
        else
            return 6'($urandom_range(1, 12));
    endfunction

    function automatic logic [7:0] pick_live();
        return live_syms[$urandom_range(0, live_syms.size() - 1)];
    endfunction

    // Driver: hold the item until the transfer, then idle for the drawn gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (s_gap != 0) begin
                s_valid <= 1'b0;
                s_gap   <= s_gap - 1;
            end else if (items_to_send.size() != 0) begin
                s_item  <= items_to_send.pop_front();
                s_valid <= 1'b1;
                s_gap   <= idle_draw(s_quiet);
                if ($urandom_range(0, 15) == 0) s_quiet <= !s_quiet;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: stall for a drawn number of cycles after each transfer
    always @(negedge aclk) begin : rx_ready
        int unsigned w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_gap   <= 0;
        end else if (m_took) begin
            w        = idle_draw(m_quiet);
            m_ready <= (w == 0);
            m_gap   <= w;
            if ($urandom_range(0, 15) == 0) m_quiet <= !m_quiet;
        end else if (m_gap != 0) begin
            m_ready <= (m_gap == 1);
            m_gap   <= m_gap - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on each input transfer, check each result transfer
    always @(posedge aclk) begin : monitor
        m_item_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            m_took <= m_valid && m_ready;
            if (s_valid && s_ready)
                pack_code_bytes(s_item);
            if (m_valid && m_ready) begin
                if (due_bytes.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected byte %02h last %0d, nothing expected",
                             $time, m_item.packed_byte, m_item.is_last);
                end else begin
                    want = due_bytes.pop_front();
                    n_bytes++;
                    if (want.is_last) n_last++;
                    if (m_item.packed_byte !== want.packed_byte
                            || m_item.is_last !== want.is_last) begin
                        err_cnt++;
                        $display("%0t: byte mismatch: expected %02h last %0d, got %02h last %0d",
                                 $time, want.packed_byte, want.is_last,
                                 m_item.packed_byte, m_item.is_last);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned k;
        s_valid   = 1'b0;
        s_item    = '0;
        m_ready   = 1'b0;
        aresetn   = 1'b0;
        s_gap     = 0;
        m_gap     = 0;
        s_quiet   = 1'b0;
        m_quiet   = 1'b0;
        pend_bits = '0;
        pend_cnt  = 0;
        err_cnt   = 0;
        n_loads   = 0;
        n_encodes = 0;
        n_flushes = 0;
        n_bytes   = 0;
        n_last    = 0;
        foreach (loaded[i]) loaded[i] = 1'b0;

        // Directed: extreme lengths and codes, zero and over-cap lengths,
        // empty flush, unused function code
        queue_item(FUNC_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
        queue_item(FUNC_LOAD, 8'd255, 32'h0000_0000, 6'd1);
        queue_item(FUNC_LOAD, 8'd1, 32'h1234_5678, 6'd0);
        queue_item(FUNC_LOAD, 8'd2, 32'hAAAA_AAAA, 6'd63);
        queue_item(FUNC_LOAD, 8'd3, 32'h8000_0001, 6'd33);
        queue_item(FUNC_LOAD, 8'd4, 32'h0000_00A5, 6'd8);
        queue_item(FUNC_LOAD, 8'd5, 32'hFFFF_FFFD, 6'd3);
        queue_item(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);
        queue_item(FUNC_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63);
        queue_item(FUNC_ENCODE, 8'd5, 32'h0, 6'd0);
        queue_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);
        queue_item(FUNC_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63);
        queue_item(FUNC_ENCODE, 8'd1, 32'h0, 6'd0);
        queue_item(FUNC_ENCODE, 8'd2, 32'h0, 6'd0);
        queue_item(FUNC_ENCODE, 8'd3, 32'h0, 6'd0);
        queue_item(FUNC_ENCODE, 8'd4, 32'h0, 6'd0);
        queue_item(FUNC_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
        queue_item(FUNC_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_item(FUNC_ENCODE, 8'd0, 32'h0, 6'd0);
        queue_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);
        queue_item(FUNC_LOAD, 8'd128, 32'h7FFF_FFFF, 6'd7);
        queue_item(FUNC_ENCODE, 8'd128, 32'h0, 6'd0);
        queue_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);

        // Random: fill a table, then mostly encodes with reloads, flushes and noise
        for (k = 0; k < 24; k++)
            queue_item(FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom, draw_len());
        for (k = 0; k < 285; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                queue_item(FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom, draw_len());
            else if (r < 82)
                queue_item(FUNC_ENCODE, pick_live(), $urandom, 6'($urandom_range(0, 63)));
            else if (r < 95)
                queue_item(FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                           6'($urandom_range(0, 63)));
            else
                queue_item(FUNC_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                           6'($urandom_range(0, 63)));
        end
        queue_item(FUNC_FLUSH, 8'd0, 32'h0, 6'd0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (items_to_send.size() != 0 || s_valid) @(posedge aclk);
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d loads, %0d encodes, %0d flushes; checked %0d bytes, %0d stream ends.",
                 n_loads, n_encodes, n_flushes, n_bytes, n_last);
        if (err_cnt == 0) begin
            $display("** huffman_code_bit_packer_unit: PASSED **");
        end else begin
            $display("** huffman_code_bit_packer_unit: FAILED **");
        end
        $finish;
    end

endmodule
